[rtl/core/sprod_pkg.sv]
// Package for the setpoint ramp output driver: word types, register
// indexes and the per-pass state and configuration structs.
// No dependencies.
`default_nettype none

package sprod_pkg;

   // Register indexes on the configuration port (byte address = 4 * index)
   localparam logic [1:0] REG_SETPOINT_MIN   = 2'd0;
   localparam logic [1:0] REG_SETPOINT_MAX   = 2'd1;
   localparam logic [1:0] REG_RAMP_PERIOD_MS = 2'd2;
   localparam logic [1:0] REG_RAMP_BYPASS    = 2'd3;

   // Reset values of the configuration registers
   localparam logic [7:0]  SETPOINT_MIN_RESET   = 8'd0;
   localparam logic [7:0]  SETPOINT_MAX_RESET   = 8'd255;
   localparam logic [15:0] RAMP_PERIOD_RESET    = 16'd0;

   localparam logic [15:0] ACC_SATURATE = 16'hFFFF;

   // One input word: one control pass
   typedef struct packed {
      logic       run_command;
      logic [7:0] setpoint;
      logic [7:0] elapsed_ms;
   } req_type;

   // One result word
   typedef struct packed {
      logic [7:0] duty;
      logic       contactor_on;
      logic [7:0] ramp_value;
      logic       target_reached;
   } rsp_type;

   // Configuration register set
   typedef struct packed {
      logic [7:0]  setpoint_min;
      logic [7:0]  setpoint_max;
      logic [15:0] ramp_period_ms;
      logic        ramp_bypass;
   } cfg_type;

   // Ramp state carried from pass to pass
   typedef struct packed {
      logic [7:0]  ramp_level;
      logic        contactor_latch;
      logic [15:0] elapsed_acc;
   } state_type;

endpackage

`default_nettype wire

[rtl/core/sprod_step.sv]
// One control pass of the ramp: clamp, target select, timed unit step
// and contactor latch. Pure combinational logic. Uses sprod_pkg.
`default_nettype none

module sprod_step (
   input  wire sprod_pkg::req_type   req,
   input  wire sprod_pkg::cfg_type   cfg,
   input  wire sprod_pkg::state_type state_cur,
   output sprod_pkg::state_type      state_next,
   output sprod_pkg::rsp_type        rsp
);

   logic [7:0]  clamped;
   logic [7:0]  target;
   logic [7:0]  level_start;
   logic        reached;
   logic [16:0] acc_sum;
   logic [15:0] acc_sat;
   logic        step_due;
   logic [7:0]  level_new;
   logic [15:0] acc_new;
   logic        latch_new;

   // Clamp setpoint; the lower limit test takes priority
   always_comb begin
      if (req.setpoint < cfg.setpoint_min) begin
         clamped = cfg.setpoint_min;
      end else if (req.setpoint > cfg.setpoint_max) begin
         clamped = cfg.setpoint_max;
      end else begin
         clamped = req.setpoint;
      end
   end

   assign target      = req.run_command ? clamped : 8'd0;
   assign level_start = cfg.ramp_bypass ? target : state_cur.ramp_level;
   assign reached     = (level_start == target);

   // Saturating elapsed-time accumulator
   assign acc_sum  = {1'b0, state_cur.elapsed_acc} + {9'd0, req.elapsed_ms};
   assign acc_sat  = acc_sum[16] ? sprod_pkg::ACC_SATURATE : acc_sum[15:0];
   assign step_due = (acc_sat >= cfg.ramp_period_ms);

   // Step one unit toward target once the period has elapsed
   always_comb begin
      level_new = level_start;
      acc_new   = 16'd0;
      if (!reached) begin
         if (step_due) begin
            if (target > level_start) begin
               level_new = level_start + 8'd1;
            end else begin
               level_new = level_start - 8'd1;
            end
         end else begin
            acc_new = acc_sat;
         end
      end
   end

   // Contactor holds while above the release level and run or latched
   assign latch_new = (level_new > cfg.setpoint_min) &&
                      (req.run_command || state_cur.contactor_latch);

   assign state_next.ramp_level      = level_new;
   assign state_next.contactor_latch = latch_new;
   assign state_next.elapsed_acc     = acc_new;

   assign rsp.duty           = latch_new ? level_new : 8'd0;
   assign rsp.contactor_on   = latch_new;
   assign rsp.ramp_value     = level_new;
   assign rsp.target_reached = reached;

endmodule

`default_nettype wire

[rtl/core/setpoint_ramp_output_driver_unit.sv]
// Top level of the setpoint ramp output driver: input register, ramp
// state, result register and APB-style register port.
// Depends on sprod_pkg and sprod_step.
`default_nettype none

// Takes one control pass word per clock while the result register drains
// and returns one result word per pass. A word is held in the input
// register, where the ramp step is computed against the stored ramp
// state, until it moves into the result register. The sustained rate is
// one word per cycle, limited only by the result register draining. The
// ramp state advances when a pass moves into the result register, so
// passes see each other's effects in order. Write the registers (min,
// max, period, bypass at byte addresses 0, 4, 8, 12) only while no word
// is in flight.
module setpoint_ramp_output_driver_unit (
   input  wire                 clock,
   input  wire                 reset,
   // input channel
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire sprod_pkg::req_type req_word,
   // result channel
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output sprod_pkg::rsp_type  rsp_word,
   // register port
   input  wire                 csr_psel,
   input  wire                 csr_penable,
   input  wire                 csr_pwrite,
   input  wire  [3:0]          csr_paddr,
   input  wire  [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   sprod_pkg::cfg_type   cfg_ff;
   sprod_pkg::state_type state_ff;
   sprod_pkg::state_type state_in;
   sprod_pkg::req_type   in_word_ff;
   sprod_pkg::rsp_type   out_word_ff;
   sprod_pkg::rsp_type   step_rsp;
   logic                 in_valid_ff;
   logic                 out_valid_ff;
   logic                 advance;
   logic                 csr_write;
   logic [1:0]           csr_index;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint_min   <= sprod_pkg::SETPOINT_MIN_RESET;
         cfg_ff.setpoint_max   <= sprod_pkg::SETPOINT_MAX_RESET;
         cfg_ff.ramp_period_ms <= sprod_pkg::RAMP_PERIOD_RESET;
         cfg_ff.ramp_bypass    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            sprod_pkg::REG_SETPOINT_MIN:   cfg_ff.setpoint_min   <= csr_pwdata[7:0];
            sprod_pkg::REG_SETPOINT_MAX:   cfg_ff.setpoint_max   <= csr_pwdata[7:0];
            sprod_pkg::REG_RAMP_PERIOD_MS: cfg_ff.ramp_period_ms <= csr_pwdata[15:0];
            sprod_pkg::REG_RAMP_BYPASS:    cfg_ff.ramp_bypass    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (csr_index)
         sprod_pkg::REG_SETPOINT_MIN:   csr_prdata = {24'd0, cfg_ff.setpoint_min};
         sprod_pkg::REG_SETPOINT_MAX:   csr_prdata = {24'd0, cfg_ff.setpoint_max};
         sprod_pkg::REG_RAMP_PERIOD_MS: csr_prdata = {16'd0, cfg_ff.ramp_period_ms};
         sprod_pkg::REG_RAMP_BYPASS:    csr_prdata = {31'd0, cfg_ff.ramp_bypass};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   // Pipeline flow: input stage moves on when the result slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_word_ff <= req_word;
      end
   end

   // Ramp pass logic
   sprod_step u_step (
      .req        (in_word_ff),
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .rsp        (step_rsp)
   );

   // Ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // Checks
   a_ready_only_blocked_when_full: assert property (
      @(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled with a free slot");

   a_ramp_unit_step: assert property (
      @(posedge clock) disable iff (reset)
      (advance && !cfg_ff.ramp_bypass) |=>
         (state_ff.ramp_level == $past(state_ff.ramp_level)) ||
         (state_ff.ramp_level == 8'($past(state_ff.ramp_level) + 8'd1)) ||
         (state_ff.ramp_level == 8'($past(state_ff.ramp_level) - 8'd1)))
      else $error("ramp level moved by more than one unit");

   a_result_matches_state: assert property (
      @(posedge clock) disable iff (reset)
      advance |=> (rsp_word.ramp_value == state_ff.ramp_level) &&
                  (rsp_word.contactor_on == state_ff.contactor_latch))
      else $error("result word disagrees with ramp state");

   a_duty_gated: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.duty != 8'd0) |->
         (rsp_word.contactor_on && rsp_word.duty == rsp_word.ramp_value))
      else $error("duty driven with contactor open");

endmodule

`default_nettype wire
